@@ design/slcf_pkg.sv @@
// Shared types and constants for the sync/length/CRC-32 framer.
// Used by every module of the block; depends on nothing else.
package slcf_pkg;

    localparam logic [31:0] CRC_POLY = 32'hEDB88320;
    localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam int CFG_IDX_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_FIRST  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_SECOND = 8'd1;

    localparam logic KIND_START = 1'b0;
    localparam logic KIND_DATA  = 1'b1;

    localparam int STEP_W = 3;

    typedef struct packed {
        logic        kind;
        logic [15:0] frame_length;
        logic [7:0]  payload_byte;
    } in_t;

    typedef struct packed {
        logic [7:0] wire_byte;
        logic       frame_end;
        logic       run_last;
        logic       misuse;
    } out_t;

    typedef enum logic [1:0] {
        JOB_MISUSE  = 2'd0,
        JOB_HEADER  = 2'd1,
        JOB_PAYLOAD = 2'd2
    } job_op_t;

    // One classified item as handed from the front part to the back part.
    typedef struct packed {
        job_op_t     op;
        logic [7:0]  data;
        logic [7:0]  sync_a;
        logic [7:0]  sync_b;
        logic [15:0] length;
        logic        trailer;
        logic [31:0] crc_final;
    } job_t;

    typedef struct packed {
        logic head_valid;
        logic full;
    } q_status_t;

endpackage

@@ design/slcf_front.sv @@
// Front part of the framer: accepts items, tracks the frame state and the CRC,
// and pushes one classified job per item. Depends on slcf_pkg.
module slcf_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    output logic             req_ready,
    input  slcf_pkg::in_t    req_item,
    input  logic [7:0]       sync_first,
    input  logic [7:0]       sync_second,
    input  slcf_pkg::q_status_t q_status,
    output logic             push,
    output slcf_pkg::job_t   job
);
    import slcf_pkg::*;

    logic        frame_open_reg, frame_open_next;
    logic [15:0] bytes_left_reg, bytes_left_next;
    logic [31:0] crc_reg, crc_next;
    logic [31:0] crc_folded;
    logic [15:0] bytes_dec;

    function automatic logic [31:0] crc_fold(input logic [31:0] crc_in, input logic [7:0] b);
        logic [31:0] c;
        c = crc_in ^ {24'd0, b};
        for (int k = 0; k < 8; k++)
        begin
            c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
        end
        return c;
    endfunction

    assign req_ready  = !q_status.full;
    assign push       = req_valid && req_ready;
    assign crc_folded = crc_fold(crc_reg, req_item.payload_byte);
    assign bytes_dec  = bytes_left_reg - 16'd1;

    always_comb
    begin
        frame_open_next = frame_open_reg;
        bytes_left_next = bytes_left_reg;
        crc_next        = crc_reg;

        job.op        = JOB_MISUSE;
        job.data      = req_item.payload_byte;
        job.sync_a    = sync_first;
        job.sync_b    = sync_second;
        job.length    = req_item.frame_length;
        job.trailer   = 1'b0;
        job.crc_final = 32'd0;

        if (req_item.kind == KIND_START)
        begin
            if (!frame_open_reg)
            begin
                job.op    = JOB_HEADER;
                // An empty frame closes at once; the CRC of nothing is all zeros.
                job.trailer     = (req_item.frame_length == 16'd0);
                job.crc_final   = 32'd0;
                crc_next        = CRC_INIT;
                bytes_left_next = req_item.frame_length;
                frame_open_next = (req_item.frame_length != 16'd0);
            end
        end
        else
        begin
            if (frame_open_reg)
            begin
                job.op          = JOB_PAYLOAD;
                job.trailer     = (bytes_dec == 16'd0);
                job.crc_final   = crc_folded ^ CRC_INIT;
                crc_next        = crc_folded;
                bytes_left_next = bytes_dec;
                frame_open_next = (bytes_dec != 16'd0);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_open_reg <= 1'b0;
            bytes_left_reg <= 16'd0;
            crc_reg        <= CRC_INIT;
        end
        else if (push)
        begin
            frame_open_reg <= frame_open_next;
            bytes_left_reg <= bytes_left_next;
            crc_reg        <= crc_next;
        end
    end

endmodule

@@ design/slcf_queue.sv @@
// Short job queue between the front and back parts of the framer.
// Depends on slcf_pkg for the job type and depth.
module slcf_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  slcf_pkg::job_t      job_in,
    input  logic                pop,
    output slcf_pkg::job_t      head,
    output slcf_pkg::q_status_t status
);
    import slcf_pkg::*;

    job_t              slot_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg, count_next;

    assign head              = slot_reg[rd_ptr_reg];
    assign status.head_valid = (count_reg != '0);
    assign status.full       = (count_reg == QCNT_W'(QDEPTH));

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + QCNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= job_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

endmodule

@@ design/slcf_back.sv @@
// Back part of the framer: expands each queued job into its output beats
// and holds them in the output register. Depends on slcf_pkg.
module slcf_back (
    input  logic                clk,
    input  logic                rst_n,
    input  slcf_pkg::job_t      head,
    input  slcf_pkg::q_status_t q_status,
    output logic                pop,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output slcf_pkg::out_t      rsp_item
);
    import slcf_pkg::*;

    logic [STEP_W-1:0] step_reg, step_next;
    logic              out_valid_reg, out_valid_next;
    out_t              out_reg;
    out_t              beat;
    logic              advance;
    logic              last;
    logic [1:0]        crc_idx;
    logic [7:0]        crc_byte;

    assign advance = q_status.head_valid && (!out_valid_reg || rsp_ready);
    assign pop     = advance && last;

    // Header beats 4..7 and payload beats 1..4 carry the CRC, low byte first.
    always_comb
    begin
        if (head.op == JOB_HEADER)
        begin
            crc_idx = step_reg[1:0];
        end
        else
        begin
            crc_idx = 2'(step_reg - STEP_W'(1));
        end
        crc_byte = head.crc_final[8*crc_idx +: 8];
    end

    always_comb
    begin
        beat = '0;
        last = 1'b1;
        case (head.op)
            JOB_HEADER:
            begin
                case (step_reg)
                    3'd0:    beat.wire_byte = head.sync_a;
                    3'd1:    beat.wire_byte = head.sync_b;
                    3'd2:    beat.wire_byte = head.length[7:0];
                    3'd3:    beat.wire_byte = head.length[15:8];
                    default: beat.wire_byte = crc_byte;
                endcase
                last = head.trailer ? (step_reg == 3'd7) : (step_reg == 3'd3);
            end
            JOB_PAYLOAD:
            begin
                beat.wire_byte = (step_reg == 3'd0) ? head.data : crc_byte;
                last = head.trailer ? (step_reg == 3'd4) : (step_reg == 3'd0);
            end
            default:
            begin
                beat.misuse = 1'b1;
            end
        endcase
        beat.run_last  = last;
        beat.frame_end = last && head.trailer && (head.op != JOB_MISUSE);
    end

    always_comb
    begin
        step_next      = step_reg;
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            step_next      = last ? '0 : step_reg + STEP_W'(1);
            out_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_reg <= beat;
        end
    end

    assign rsp_valid = out_valid_reg;
    assign rsp_item  = out_reg;

endmodule

@@ design/sync_length_crc32_framer.sv @@
// Framer top level: two sync bytes, 16-bit length, payload, inverted CRC-32.
// The first beat of an item passes through the job queue and then into the output register.
// Throughput: one payload byte per cycle while rsp_ready holds; a start item expands into 4 beats (8 when
// empty) and a frame-closing byte into 5, paced by the single output beat register.
// Reset clears the frame state, CRC, queue, output valid and both sync registers.
// Depends on slcf_pkg, slcf_front, slcf_queue and slcf_back.
module sync_length_crc32_framer (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              req_valid,
    output logic                              req_ready,
    input  slcf_pkg::in_t                     req_item,
    output logic                              rsp_valid,
    input  logic                              rsp_ready,
    output slcf_pkg::out_t                    rsp_item,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [slcf_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [7:0]                        cfg_data
);
    import slcf_pkg::*;

    logic      [7:0] sync_first_reg;
    logic      [7:0] sync_second_reg;
    logic            push;
    logic            pop;
    job_t            job;
    job_t            head;
    q_status_t       q_status;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_first_reg  <= 8'd0;
            sync_second_reg <= 8'd0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_SYNC_FIRST:  sync_first_reg  <= cfg_data;
                CFG_SYNC_SECOND: sync_second_reg <= cfg_data;
                default:         ;
            endcase
        end
    end

    slcf_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_ready   (req_ready),
        .req_item    (req_item),
        .sync_first  (sync_first_reg),
        .sync_second (sync_second_reg),
        .q_status    (q_status),
        .push        (push),
        .job         (job)
    );

    slcf_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .job_in (job),
        .pop    (pop),
        .head   (head),
        .status (q_status)
    );

    slcf_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .q_status  (q_status),
        .pop       (pop),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_item  (rsp_item)
    );

endmodule

@@ dv/sync_length_crc32_framer_tb.sv @@
// Self-checking testbench for the sync/length/CRC-32 framer: directed table, then random frames.
// Expected beats come from the table where spelt out, else from a behavioural copy in this file.
// Depends on slcf_pkg and sync_length_crc32_framer only.
`timescale 1ns / 100ps

module sync_length_crc32_framer_tb;

    import slcf_pkg::*;

    localparam int DRAIN_PAUSE    = 8;
    localparam int HOLD_OFF       = 150;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int RANDOM_ITEMS   = 60;
    localparam int FILL_BYTES     = 32;

    // One line of stimulus; a non-zero n_typed means the expected beats are spelt out here.
    typedef struct packed {
        logic        is_cfg;
        logic [7:0]  cfg_lead;
        logic [7:0]  cfg_follow;
        in_t         item;
        logic [3:0]  n_typed;
        logic [63:0] typed_bytes;
        logic        typed_end;
        logic        typed_bad;
    } stim_row_t;

    logic                 clk;
    logic                 rst_n;
    logic                 req_valid;
    logic                 req_ready;
    in_t                  req_item;
    logic                 rsp_valid;
    logic                 rsp_ready;
    out_t                 rsp_item;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [7:0]           cfg_data;

    // Framer state as the testbench sees it.
    logic [7:0]  sync_lead;
    logic [7:0]  sync_follow;
    logic        frame_is_open;
    logic [15:0] bytes_owed;
    logic [31:0] crc_acc;

    out_t        burst[$];
    out_t        wire_due[$];
    stim_row_t   rows_pending[$];

    int unsigned fault_count  = 0;
    int unsigned quiet_cycles = 0;
    int          send_gap_pct  = 0;
    int          rsp_stall_pct = 0;
    int          hold_left     = 0;

    sync_length_crc32_framer DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_item  (req_item),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_item  (rsp_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic logic [31:0] crc32_fold_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        int          k;
        c = crc ^ {24'h0, b};
        for (k = 0; k < 8; k++)
            c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
        return c;
    endfunction

    function automatic out_t wire_beat(input logic [7:0] b, input logic fe, input logic bad);
        out_t o;
        o.wire_byte = b;
        o.frame_end = fe;
        o.run_last  = 1'b0;
        o.misuse    = bad;
        return o;
    endfunction

    // Works out the beats one accepted item causes and advances the framer state.
    function automatic void predict_burst(input in_t it);
        logic [31:0] fin;
        logic        closing;
        int          i;
        burst.delete();
        closing = 1'b0;
        if ((it.kind == KIND_START) == frame_is_open)
        begin
            burst.push_back(wire_beat(8'h00, 1'b0, 1'b1));
        end
        else if (it.kind == KIND_START)
        begin
            burst.push_back(wire_beat(sync_lead, 1'b0, 1'b0));
            burst.push_back(wire_beat(sync_follow, 1'b0, 1'b0));
            burst.push_back(wire_beat(it.frame_length[7:0], 1'b0, 1'b0));
            burst.push_back(wire_beat(it.frame_length[15:8], 1'b0, 1'b0));
            crc_acc       = CRC_INIT;
            bytes_owed    = it.frame_length;
            frame_is_open = (it.frame_length != 16'h0000);
            closing       = (it.frame_length == 16'h0000);
        end
        else
        begin
            burst.push_back(wire_beat(it.payload_byte, 1'b0, 1'b0));
            crc_acc    = crc32_fold_byte(crc_acc, it.payload_byte);
            bytes_owed = bytes_owed - 16'd1;
            closing    = (bytes_owed == 16'h0000);
        end
        if (closing)
        begin
            fin = crc_acc ^ CRC_INIT;
            for (i = 0; i < 4; i++)
                burst.push_back(wire_beat(fin[8*i +: 8], i == 3, 1'b0));
            frame_is_open = 1'b0;
            bytes_owed    = 16'h0000;
        end
        burst[burst.size()-1].run_last = 1'b1;
    endfunction

    function automatic stim_row_t row_of(input logic kind, input logic [15:0] len,
                                         input logic [7:0] pb, input int n,
                                         input logic [63:0] bytes, input logic fe,
                                         input logic bad);
        stim_row_t row;
        row                   = '0;
        row.item.kind         = kind;
        row.item.frame_length = len;
        row.item.payload_byte = pb;
        row.n_typed           = 4'(n);
        row.typed_bytes       = bytes;
        row.typed_end         = fe;
        row.typed_bad         = bad;
        return row;
    endfunction

    function automatic stim_row_t sync_row(input logic [7:0] lead, input logic [7:0] follow);
        stim_row_t row;
        row            = '0;
        row.is_cfg     = 1'b1;
        row.cfg_lead   = lead;
        row.cfg_follow = follow;
        return row;
    endfunction

    // Observes every handshake on the pre-edge values and keeps the expectations in order.
    always @(posedge clk)
    begin : scoreboard
        stim_row_t row;
        out_t      got;
        out_t      want;
        logic      moved;
        int        i;
        if (rst_n)
        begin
            moved = 1'b0;
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_SYNC_FIRST)
                    sync_lead = cfg_data;
                else if (cfg_index == CFG_SYNC_SECOND)
                    sync_follow = cfg_data;
                moved = 1'b1;
            end
            if (req_valid && req_ready)
            begin
                row = rows_pending.pop_front();
                predict_burst(req_item);
                if (row.n_typed != 0)
                begin
                    for (i = 0; i < row.n_typed; i++)
                    begin
                        want = wire_beat(row.typed_bytes[63-8*i -: 8],
                                         row.typed_end && (i == row.n_typed - 1),
                                         row.typed_bad);
                        want.run_last = (i == row.n_typed - 1);
                        wire_due.push_back(want);
                    end
                end
                else
                begin
                    foreach (burst[j])
                        wire_due.push_back(burst[j]);
                end
                moved = 1'b1;
            end
            if (rsp_valid && rsp_ready)
            begin
                got = rsp_item;
                if (wire_due.size() == 0)
                begin
                    if (fault_count < 10)
                        $display("unexpected beat: byte %02h end %0b last %0b misuse %0b",
                                 got.wire_byte, got.frame_end, got.run_last, got.misuse);
                    fault_count++;
                end
                else
                begin
                    want = wire_due.pop_front();
                    if (got.wire_byte !== want.wire_byte || got.frame_end !== want.frame_end ||
                        got.run_last !== want.run_last || got.misuse !== want.misuse)
                    begin
                        if (fault_count < 10)
                            $display({"mismatch: expected byte %02h end %0b last %0b misuse %0b,",
                                      " got byte %02h end %0b last %0b misuse %0b"},
                                     want.wire_byte, want.frame_end, want.run_last, want.misuse,
                                     got.wire_byte, got.frame_end, got.run_last, got.misuse);
                        fault_count++;
                    end
                end
                moved = 1'b1;
            end
            quiet_cycles = moved ? 0 : quiet_cycles + 1;
        end
    end

    initial
    begin : watchdog
        wait (rst_n === 1'b1);
        while (quiet_cycles < WATCHDOG_LIMIT)
            @(posedge clk);
        $display("[FAIL] regression broken");
        $finish;
    end

    // The output side stalls at random, or holds off entirely while hold_left runs down.
    initial
    begin : rsp_side
        rsp_ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                rsp_ready <= 1'b0;
                hold_left = hold_left - 1;
            end
            else
            begin
                rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
            end
        end
    end

    task automatic offer(input stim_row_t row);
        while ($urandom_range(99) < send_gap_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        rows_pending.push_back(row);
        req_item  <= row.item;
        req_valid <= 1'b1;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
    endtask

    task automatic settle();
        req_valid <= 1'b0;
        @(posedge clk);
        while (wire_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_PAUSE) @(posedge clk);
    endtask

    task automatic write_syncs(input logic [7:0] lead, input logic [7:0] follow);
        cfg_index <= CFG_SYNC_FIRST;
        cfg_data  <= lead;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_index <= CFG_SYNC_SECOND;
        cfg_data  <= follow;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Mostly well-formed frames with random content, with stray bytes and starts mixed in.
    task automatic random_phase(input int gap, input int stall, input int hold);
        stim_row_t row;
        int        plan_left;
        int        k;
        int        r;
        int        pick;
        send_gap_pct  = gap;
        rsp_stall_pct = stall;
        hold_left     = hold;
        plan_left     = 0;
        for (k = 0; k < RANDOM_ITEMS || plan_left != 0; k++)
        begin
            row                   = '0;
            row.item.frame_length = 16'($urandom_range(65535));
            row.item.payload_byte = 8'($urandom_range(255));
            r                     = $urandom_range(99);
            if (plan_left == 0)
            begin
                if (r < 85)
                begin
                    pick                  = $urandom_range(99);
                    row.item.kind         = KIND_START;
                    row.item.frame_length = 16'((pick < 10) ? 0 :
                                                (pick < 80) ? $urandom_range(12, 1) :
                                                (pick < 96) ? $urandom_range(48, 13) :
                                                              $urandom_range(200, 49));
                    plan_left             = int'(row.item.frame_length);
                end
                else
                begin
                    row.item.kind = KIND_DATA;
                end
            end
            else if (r < 90 || k >= RANDOM_ITEMS)
            begin
                row.item.kind = KIND_DATA;
                plan_left     = plan_left - 1;
            end
            else
            begin
                row.item.kind = KIND_START;
            end
            offer(row);
        end
        settle();
    endtask

    initial
    begin : stimulus
        stim_row_t directed_rows[$];
        stim_row_t row;

        rst_n     = 1'b0;
        req_valid = 1'b0;
        req_item  = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_SYNC_FIRST;
        cfg_data  = 8'h00;

        sync_lead     = 8'h00;
        sync_follow   = 8'h00;
        frame_is_open = 1'b0;
        bytes_owed    = 16'h0000;
        crc_acc       = CRC_INIT;

        // Straight after reset both sync bytes are zero.
        directed_rows.push_back(row_of(KIND_DATA, 16'h0000, 8'hA5, 1, 64'h0, 1'b0, 1'b1));
        directed_rows.push_back(row_of(KIND_START, 16'h0000, 8'h00, 8, 64'h0, 1'b1, 1'b0));
        directed_rows.push_back(row_of(KIND_START, 16'h0001, 8'h00, 4,
                                       64'h0000_0100_0000_0000, 1'b0, 1'b0));
        directed_rows.push_back(row_of(KIND_START, 16'h0005, 8'h00, 1, 64'h0, 1'b0, 1'b1));
        directed_rows.push_back(row_of(KIND_DATA, 16'h0000, 8'h00, 0, 64'h0, 1'b0, 1'b0));
        directed_rows.push_back(sync_row(8'hFF, 8'h00));
        directed_rows.push_back(row_of(KIND_START, 16'h0000, 8'h00, 8,
                                       64'hFF00_0000_0000_0000, 1'b1, 1'b0));
        directed_rows.push_back(row_of(KIND_START, 16'h0002, 8'h00, 4,
                                       64'hFF00_0200_0000_0000, 1'b0, 1'b0));
        directed_rows.push_back(row_of(KIND_DATA, 16'h0000, 8'hFF, 0, 64'h0, 1'b0, 1'b0));
        directed_rows.push_back(row_of(KIND_DATA, 16'hFFFF, 8'h80, 0, 64'h0, 1'b0, 1'b0));
        directed_rows.push_back(sync_row(8'h00, 8'hFF));
        directed_rows.push_back(row_of(KIND_START, 16'h0003, 8'hFF, 4,
                                       64'h00FF_0300_0000_0000, 1'b0, 1'b0));
        directed_rows.push_back(row_of(KIND_START, 16'hFFFF, 8'h00, 1, 64'h0, 1'b0, 1'b1));
        directed_rows.push_back(row_of(KIND_START, 16'h0000, 8'h00, 1, 64'h0, 1'b0, 1'b1));
        directed_rows.push_back(row_of(KIND_DATA, 16'h0000, 8'h01, 0, 64'h0, 1'b0, 1'b0));
        directed_rows.push_back(row_of(KIND_DATA, 16'h0000, 8'h7F, 0, 64'h0, 1'b0, 1'b0));
        directed_rows.push_back(row_of(KIND_DATA, 16'h0000, 8'hFE, 0, 64'h0, 1'b0, 1'b0));
        directed_rows.push_back(row_of(KIND_DATA, 16'h0000, 8'h55, 1, 64'h0, 1'b0, 1'b1));
        // This frame stays open for the filler below.
        directed_rows.push_back(row_of(KIND_START, 16'h0020, 8'h00, 4,
                                       64'h00FF_2000_0000_0000, 1'b0, 1'b0));
        directed_rows.push_back(row_of(KIND_START, 16'hAAAA, 8'h00, 1, 64'h0, 1'b0, 1'b1));
        directed_rows.push_back(row_of(KIND_START, 16'h5555, 8'h00, 1, 64'h0, 1'b0, 1'b1));

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[r])
        begin
            if (directed_rows[r].is_cfg)
            begin
                settle();
                write_syncs(directed_rows[r].cfg_lead, directed_rows[r].cfg_follow);
            end
            else
            begin
                offer(directed_rows[r]);
            end
        end

        // Fill the open frame at full rate until its trailer follows.
        repeat (FILL_BYTES)
        begin
            row                   = '0;
            row.item.kind         = KIND_DATA;
            row.item.frame_length = 16'($urandom_range(65535));
            row.item.payload_byte = 8'($urandom_range(255));
            offer(row);
        end
        settle();

        write_syncs(8'hFF, 8'hFF);
        random_phase(0, 0, 0);
        write_syncs(8'($urandom_range(255)), 8'($urandom_range(255)));
        random_phase(54, 0, 0);
        write_syncs(8'($urandom_range(255)), 8'($urandom_range(255)));
        random_phase(0, 54, HOLD_OFF);
        write_syncs(8'($urandom_range(255)), 8'($urandom_range(255)));
        random_phase(16, 16, 0);

        if (fault_count == 0 && wire_due.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

@@ sim.f @@
design/slcf_pkg.sv
design/slcf_front.sv
design/slcf_queue.sv
design/slcf_back.sv
design/sync_length_crc32_framer.sv
dv/sync_length_crc32_framer_tb.sv
